// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the sorted list RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define SUL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define SUL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/sul_pkg.sv
// ----------------------------------------------------------------------------
// sul_pkg
// Shared constants and types for the sorted unique list and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package sul_pkg;

  // Default sizes
  localparam int DEPTH_DEF      = 8;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed field widths of the ports
  localparam int KIND_W   = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 4;

  // Operation codes
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DUMP   = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUP      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

  // Command broadcast to every cell
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_ROTATE = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     cmp_en;
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: rtl/sul_cell.sv
// ----------------------------------------------------------------------------
// sul_cell
// One slot of the sorted list: holds an entry, compares it with the key and
// moves data to or from its neighbors on insert, delete and dump rotation.
// ----------------------------------------------------------------------------
`default_nettype none

module sul_cell #(
  parameter int DATA_WIDTH = sul_pkg::DATA_WIDTH_DEF,
  parameter int CNT_W      = 4,
  parameter int IDX        = 0
) (
  input  wire logic                  clk,
  input  wire sul_pkg::cell_ctl_t    ctl,
  input  wire logic [CNT_W-1:0]      count,
  input  wire logic [DATA_WIDTH-1:0] key,
  input  wire logic [DATA_WIDTH-1:0] left_data,
  input  wire logic                  left_shift,
  input  wire logic [DATA_WIDTH-1:0] right_data,
  input  wire logic [DATA_WIDTH-1:0] wrap_data,
  output logic [DATA_WIDTH-1:0]      data,
  output logic                       shift,
  output logic                       match
);

  localparam logic [CNT_W-1:0] MY_IDX   = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] NEXT_IDX = CNT_W'(IDX + 1);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;
  logic                  gt_r;
  logic                  eq_r;
  logic                  occ;
  logic                  at_cnt;
  logic                  ge;

  assign occ    = (MY_IDX < count);
  assign at_cnt = (MY_IDX == count);
  assign ge     = occ & (gt_r | eq_r);

  // Slots from the insert point up to the first free slot move up
  assign shift = occ ? gt_r : at_cnt;
  assign match = occ & eq_r;
  assign data  = data_r;

  // Pick the next entry from the command
  always_comb begin
    data_nxt = data_r;
    unique case (ctl.op)
      sul_pkg::OP_INSERT: begin
        if (shift) begin
          data_nxt = left_shift ? left_data : key;
        end
      end
      sul_pkg::OP_DELETE: begin
        if (ge) begin
          data_nxt = right_data;
        end
      end
      sul_pkg::OP_ROTATE: begin
        if (NEXT_IDX < count) begin
          data_nxt = right_data;
        end else if (NEXT_IDX == count) begin
          data_nxt = wrap_data;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  // Hold entry and compare flags
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (ctl.cmp_en) begin
      gt_r <= ($signed(data_r) > $signed(key));
      eq_r <= (data_r == key);
    end
  end

endmodule

`default_nettype wire

// File: rtl/sorted_unique_list.sv
// ----------------------------------------------------------------------------
// sorted_unique_list
// Bounded set of signed values kept in ascending order in a row of cells,
// with insert, delete and in-order dump.
// ----------------------------------------------------------------------------
//   Channel | Direction | Handshake           | Payload
//   in_     | input     | in_valid/in_ready   | in_kind, in_value
//   out_    | output    | out_valid/out_ready | out_status, out_entry,
//           |           |                     | out_count, out_last
//
// Insert and delete step through accept, compare in every cell, then shift
// the cells and write the result register. Dump streams one entry a cycle,
// while the result register is free, after the compare step, rotating the
// cell row once around; an empty dump gives only its status. A stalled
// result register holds the sequencer; a new transaction is taken once idle.
// Reset clears the count; cell contents are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_unique_list #(
  parameter int DEPTH      = sul_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = sul_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [sul_pkg::KIND_W-1:0]          in_kind,
  input  wire logic signed [sul_pkg::VALUE_W-1:0]  in_value,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [sul_pkg::STATUS_W-1:0]             out_status,
  output logic signed [sul_pkg::VALUE_W-1:0]       out_entry,
  output logic [sul_pkg::COUNT_W-1:0]              out_count,
  output logic                                     out_last
);

  `include "assert_macros.svh"

  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_RES  = 4'b0100,
    S_DUMP = 4'b1000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [sul_pkg::KIND_W-1:0]    kind_r;
  logic [DATA_WIDTH-1:0]         key_r;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [CNT_W-1:0]              left_r, left_nxt;

  logic                          out_valid_r;
  logic [sul_pkg::STATUS_W-1:0]  out_status_r;
  logic [sul_pkg::VALUE_W-1:0]   out_entry_r;
  logic [sul_pkg::COUNT_W-1:0]   out_count_r;
  logic                          out_last_r;

  sul_pkg::cell_ctl_t            ctl;
  logic                          res_we;
  logic [sul_pkg::STATUS_W-1:0]  res_status;
  logic [sul_pkg::VALUE_W-1:0]   res_entry;
  logic                          res_last;

  logic [DATA_WIDTH-1:0]         cell_data [DEPTH];
  logic [DEPTH-1:0]              cell_shift;
  logic [DEPTH-1:0]              cell_match;

  logic                          out_free;
  logic                          is_full;
  logic                          is_empty;
  logic                          any_match;
  logic                          head_ordered;

  assign in_ready  = (state_r == S_IDLE);
  assign out_free  = !out_valid_r || out_ready;
  assign is_full   = (count_r == CNT_W'(DEPTH));
  assign is_empty  = (count_r == '0);
  assign any_match = |cell_match;

  // Row of cells, each linked to its neighbors
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_d;
    logic                  left_s;
    logic [DATA_WIDTH-1:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = key_r;
      assign left_s = 1'b0;
    end else begin : g_mid
      assign left_d = cell_data[i-1];
      assign left_s = cell_shift[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_d = cell_data[i];
    end else begin : g_inner
      assign right_d = cell_data[i+1];
    end

    sul_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W),
      .IDX        (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .count      (count_r),
      .key        (key_r),
      .left_data  (left_d),
      .left_shift (left_s),
      .right_data (right_d),
      .wrap_data  (cell_data[0]),
      .data       (cell_data[i]),
      .shift      (cell_shift[i]),
      .match      (cell_match[i])
    );
  end

  // Sequence one transaction: compare, then update or stream the dump
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    left_nxt   = left_r;
    ctl.op     = sul_pkg::OP_HOLD;
    ctl.cmp_en = 1'b0;
    res_we     = 1'b0;
    res_status = sul_pkg::ST_OK;
    res_entry  = '0;
    res_last   = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && (in_kind == sul_pkg::KIND_INSERT ||
                         in_kind == sul_pkg::KIND_DELETE ||
                         in_kind == sul_pkg::KIND_DUMP)) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        ctl.cmp_en = 1'b1;
        state_nxt  = S_RES;
      end
      S_RES: begin
        case (kind_r)
          sul_pkg::KIND_INSERT: begin
            if (out_free) begin
              res_we    = 1'b1;
              state_nxt = S_IDLE;
              if (is_full) begin
                res_status = sul_pkg::ST_FULL;
              end else if (any_match) begin
                res_status = sul_pkg::ST_DUP;
              end else begin
                ctl.op    = sul_pkg::OP_INSERT;
                count_nxt = count_r + 1'b1;
              end
            end
          end
          sul_pkg::KIND_DELETE: begin
            if (out_free) begin
              res_we    = 1'b1;
              state_nxt = S_IDLE;
              if (is_empty) begin
                res_status = sul_pkg::ST_EMPTY;
              end else if (!any_match) begin
                res_status = sul_pkg::ST_NOTFOUND;
              end else begin
                ctl.op    = sul_pkg::OP_DELETE;
                count_nxt = count_r - 1'b1;
              end
            end
          end
          default: begin
            if (!is_empty) begin
              left_nxt  = count_r;
              state_nxt = S_DUMP;
            end else if (out_free) begin
              res_we     = 1'b1;
              res_status = sul_pkg::ST_EMPTY;
              state_nxt  = S_IDLE;
            end
          end
        endcase
      end
      S_DUMP: begin
        if (out_free) begin
          res_we    = 1'b1;
          res_entry = sul_pkg::VALUE_W'($signed(cell_data[0]));
          res_last  = (left_r == CNT_W'(1));
          ctl.op    = sul_pkg::OP_ROTATE;
          left_nxt  = left_r - 1'b1;
          if (res_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      left_r  <= left_nxt;
      if (res_we) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture the transaction and the result payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_r <= in_kind;
      key_r  <= DATA_WIDTH'(in_value);
    end
    if (res_we) begin
      out_status_r <= res_status;
      out_entry_r  <= res_entry;
      out_count_r  <= sul_pkg::COUNT_W'(count_nxt);
      out_last_r   <= res_last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_entry  = out_entry_r;
  assign out_count  = out_count_r;
  assign out_last   = out_last_r;

  // Checks
  assign head_ordered = $signed(cell_data[0]) < $signed(cell_data[1]);

  `SUL_ASSERT(a_count_bound, count_r <= CNT_W'(DEPTH), "count above depth")
  `SUL_ASSERT(a_dump_left, state_r != S_DUMP || left_r != '0, "dump with nothing left")
  `SUL_ASSERT(a_sorted, state_r == S_DUMP || count_r < CNT_W'(2) || head_ordered, "unordered")
  `SUL_ASSERT_NEXT(a_dump_end, state_r == S_DUMP && res_we && res_last, state_r == S_IDLE, "dump did not finish")

endmodule

`default_nettype wire

// File: tb/tb_sorted_unique_list.sv
// ----------------------------------------------------------------------------
// tb_sorted_unique_list
// Drives insert, delete and dump transactions into the sorted unique list and
// checks every result against a behavioral copy of the ordered set. A short
// table of directed rows comes first, then random sequences that fill and
// drain the set, with random idle bursts on both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sorted_unique_list;

  // Kind code that the block ignores
  localparam logic [sul_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int SET_DEPTH    = sul_pkg::DEPTH_DEF;
  localparam int RANDOM_OPS   = 287;
  localparam int QUIET_FROM   = 247;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [sul_pkg::STATUS_W-1:0]       status;
    logic signed [sul_pkg::VALUE_W-1:0] entry;
    logic [sul_pkg::COUNT_W-1:0]        count;
    logic                               last;
  } list_result_t;

  typedef struct {
    logic [sul_pkg::KIND_W-1:0]         kind;
    logic signed [sul_pkg::VALUE_W-1:0] value;
    bit                                 typed;
    logic [sul_pkg::STATUS_W-1:0]       status;
    logic [sul_pkg::COUNT_W-1:0]        count;
  } op_row_t;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic [sul_pkg::KIND_W-1:0]         in_kind = '0;
  logic signed [sul_pkg::VALUE_W-1:0] in_value = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic [sul_pkg::STATUS_W-1:0]       out_status;
  logic signed [sul_pkg::VALUE_W-1:0] out_entry;
  logic [sul_pkg::COUNT_W-1:0]        out_count;
  logic                               out_last;

  // Shadow copy of the ordered set
  logic signed [sul_pkg::VALUE_W-1:0] set_vals [SET_DEPTH];
  int                                 set_len = 0;
  list_result_t                       awaited_results [$];

  int tx_idle_pct = 30;
  int rx_idle_pct = 30;
  int rx_stall_left = 0;
  int mismatch_cnt = 0;
  int cycle_cnt = 0;

  logic signed [sul_pkg::VALUE_W-1:0] value_pool [12] = '{
    32'sh8000_0000, 32'sh7fff_ffff, 32'sd0, -32'sd1, 32'sd1, -32'sd2,
    32'sd2, 32'sd1000, -32'sd1000, 32'sh8000_0001, 32'sh7fff_fffe, 32'sd77
  };

  op_row_t directed_ops [23] = '{
    '{sul_pkg::KIND_DUMP,   32'sd0,         1'b1, sul_pkg::ST_EMPTY,    4'd0},
    '{sul_pkg::KIND_DELETE, 32'sd5,         1'b1, sul_pkg::ST_EMPTY,    4'd0},
    '{KIND_UNUSED,          32'sd9,         1'b0, sul_pkg::ST_OK,       4'd0},
    '{sul_pkg::KIND_INSERT, 32'sd0,         1'b1, sul_pkg::ST_OK,       4'd1},
    '{sul_pkg::KIND_INSERT, 32'sh7fff_ffff, 1'b1, sul_pkg::ST_OK,       4'd2},
    '{sul_pkg::KIND_INSERT, 32'sh8000_0000, 1'b1, sul_pkg::ST_OK,       4'd3},
    '{sul_pkg::KIND_INSERT, 32'sd0,         1'b1, sul_pkg::ST_DUP,      4'd3},
    '{sul_pkg::KIND_INSERT, -32'sd1,        1'b1, sul_pkg::ST_OK,       4'd4},
    '{sul_pkg::KIND_INSERT, 32'sd1,         1'b1, sul_pkg::ST_OK,       4'd5},
    '{sul_pkg::KIND_DUMP,   32'sd0,         1'b0, sul_pkg::ST_OK,       4'd0},
    '{sul_pkg::KIND_DELETE, 32'sd7,         1'b1, sul_pkg::ST_NOTFOUND, 4'd5},
    '{sul_pkg::KIND_INSERT, 32'sd100,       1'b1, sul_pkg::ST_OK,       4'd6},
    '{sul_pkg::KIND_INSERT, -32'sd100,      1'b1, sul_pkg::ST_OK,       4'd7},
    '{sul_pkg::KIND_INSERT, 32'sd50,        1'b1, sul_pkg::ST_OK,       4'd8},
    '{sul_pkg::KIND_INSERT, 32'sd3,         1'b1, sul_pkg::ST_FULL,     4'd8},
    '{sul_pkg::KIND_DUMP,   32'sh7fff_ffff, 1'b0, sul_pkg::ST_OK,       4'd0},
    '{sul_pkg::KIND_DELETE, 32'sh8000_0000, 1'b1, sul_pkg::ST_OK,       4'd7},
    '{sul_pkg::KIND_DELETE, 32'sh7fff_ffff, 1'b1, sul_pkg::ST_OK,       4'd6},
    '{sul_pkg::KIND_DELETE, 32'sd0,         1'b1, sul_pkg::ST_OK,       4'd5},
    '{KIND_UNUSED,          -32'sd1,        1'b0, sul_pkg::ST_OK,       4'd0},
    '{sul_pkg::KIND_DUMP,   32'sd0,         1'b0, sul_pkg::ST_OK,       4'd0},
    '{sul_pkg::KIND_INSERT, 32'sh8000_0000, 1'b1, sul_pkg::ST_OK,       4'd6},
    '{sul_pkg::KIND_DUMP,   -32'sd1,        1'b0, sul_pkg::ST_OK,       4'd0}
  };

  sorted_unique_list dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_kind    (in_kind),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .out_entry  (out_entry),
    .out_count  (out_count),
    .out_last   (out_last)
  );

  always #5 clk = ~clk;

  // Apply one operation to the shadow set; queue its results when asked
  function automatic void apply_list_op(input logic [sul_pkg::KIND_W-1:0] kind,
                                        input logic signed [sul_pkg::VALUE_W-1:0] value,
                                        input bit record);
    list_result_t r;
    int           pos;
    bit           found;
    r = '{status: sul_pkg::ST_OK, entry: '0, count: '0, last: 1'b1};
    pos = set_len;
    found = 1'b0;
    for (int i = 0; i < set_len; i++) begin
      if (!found && set_vals[i] == value) begin
        found = 1'b1;
        pos = i;
      end
    end
    case (kind)
      sul_pkg::KIND_INSERT: begin
        if (set_len >= SET_DEPTH) begin
          r.status = sul_pkg::ST_FULL;
        end else if (found) begin
          r.status = sul_pkg::ST_DUP;
        end else begin
          pos = set_len;
          for (int i = set_len - 1; i >= 0; i--) begin
            if (set_vals[i] > value) pos = i;
          end
          for (int i = set_len; i > pos; i--) set_vals[i] = set_vals[i-1];
          set_vals[pos] = value;
          set_len++;
        end
      end
      sul_pkg::KIND_DELETE: begin
        if (set_len == 0) begin
          r.status = sul_pkg::ST_EMPTY;
        end else if (!found) begin
          r.status = sul_pkg::ST_NOTFOUND;
        end else begin
          for (int i = pos; i + 1 < set_len; i++) set_vals[i] = set_vals[i+1];
          set_len--;
        end
      end
      sul_pkg::KIND_DUMP: begin
        if (set_len == 0) r.status = sul_pkg::ST_EMPTY;
      end
      default: return;
    endcase
    if (!record) return;
    r.count = sul_pkg::COUNT_W'(set_len);
    if (kind == sul_pkg::KIND_DUMP && set_len != 0) begin
      for (int i = 0; i < set_len; i++) begin
        r.entry = set_vals[i];
        r.last  = (i == set_len - 1);
        awaited_results.push_back(r);
      end
    end else begin
      awaited_results.push_back(r);
    end
  endfunction

  // Present one transaction, hold it until accepted, then predict
  task automatic send_op(input op_row_t row);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < tx_idle_pct) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= row.kind;
    in_value <= row.value;
    do @(posedge clk); while (!in_ready);
    apply_list_op(row.kind, row.value, !row.typed);
    if (row.typed) awaited_results.push_back('{row.status, '0, row.count, 1'b1});
  endtask

  // Drop valid and hold off until every queued result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  // Result side: stall in random bursts
  always @(posedge clk) begin
    if (rx_stall_left > 0) begin
      rx_stall_left <= rx_stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < rx_idle_pct) begin
      rx_stall_left <= $urandom_range(0, 5);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result: status %0d entry %0d count %0d last %0d",
                   out_status, out_entry, out_count, out_last);
      end else begin
        want = awaited_results.pop_front();
        if (out_status !== want.status || out_entry !== want.entry ||
            out_count !== want.count || out_last !== want.last) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("result mismatch: exp status %0d entry %0d count %0d last %0d, got status %0d entry %0d count %0d last %0d",
                     want.status, want.entry, want.count, want.last,
                     out_status, out_entry, out_count, out_last);
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    op_row_t row;
    int      phase;
    int      roll;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    foreach (directed_ops[i]) send_op(directed_ops[i]);
    drain_results();

    // Random sequences: alternate filling, draining and mixed phases
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n == 140) drain_results();
      if (n >= QUIET_FROM) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else if (n % 25 == 0) begin
        tx_idle_pct = 30 * $urandom_range(0, 2);
        rx_idle_pct = 30 * $urandom_range(0, 2);
      end
      phase = (n / 40) % 3;
      roll = $urandom_range(0, 99);
      row.typed  = 1'b0;
      row.status = sul_pkg::ST_OK;
      row.count  = '0;
      case (phase)
        0: row.kind = (roll < 65) ? sul_pkg::KIND_INSERT :
                      (roll < 80) ? sul_pkg::KIND_DELETE :
                      (roll < 95) ? sul_pkg::KIND_DUMP : KIND_UNUSED;
        1: row.kind = (roll < 15) ? sul_pkg::KIND_INSERT :
                      (roll < 80) ? sul_pkg::KIND_DELETE :
                      (roll < 95) ? sul_pkg::KIND_DUMP : KIND_UNUSED;
        default: row.kind = (roll < 40) ? sul_pkg::KIND_INSERT :
                            (roll < 75) ? sul_pkg::KIND_DELETE :
                            (roll < 95) ? sul_pkg::KIND_DUMP : KIND_UNUSED;
      endcase
      roll = $urandom_range(0, 99);
      if (roll < 50)
        row.value = value_pool[$urandom_range(0, 11)];
      else if (roll < 75 && set_len != 0)
        row.value = set_vals[$urandom_range(0, set_len - 1)];
      else
        row.value = $urandom;
      send_op(row);
    end

    drain_results();
    repeat (30) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
